// ===== hw/rtl/sbg_pkg.sv =====
//------------------------------------------------------------------------------
// sbg_pkg: shared types and constants for the 512-bit hash engine
// S-box, linear-map seeds, round constants and sequencer state type.
//------------------------------------------------------------------------------
package sbg_pkg;

    localparam int WordW      = 64;
    localparam int BlockWords = 8;
    localparam int Rounds     = 12;
    localparam int BlockW     = WordW * BlockWords;

    typedef logic [BlockW-1:0] t_block;

    typedef enum logic [3:0] {
        ST_LOAD,     // collecting words
        ST_KEY0,     // key = LPS(h ^ n) in the block pass, LPS(h) in the length and checksum passes
        ST_INIT,     // state = key ^ m
        ST_RSTATE,   // state = LPS(state)
        ST_RKEY,     // key = LPS(key ^ C)
        ST_RMIX,     // state ^= key
        ST_FIN,      // h ^= state ^ m, sums update
        ST_OUT       // emitting digest words
    } t_state;

    typedef logic [7:0] t_sbox [256];
    localparam t_sbox SBOX = '{
     8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
     8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
     8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
     8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
     8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
     8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
     8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
     8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
     8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
     8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
     8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
     8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
     8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
     8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
     8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
     8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
    };

    typedef logic [63:0] t_seed [8];
    localparam t_seed LSEED = '{
     64'h8e20faa72ba0b470, 64'ha011d380818e8f40, 64'h90dab52a387ae76f, 64'h9d4df05d5f661451,
     64'h86275df09ce8aaa8, 64'h456c34887a3805b9, 64'he4fa2054a80b329c, 64'h70a6a56e2440598e
    };

    // round constants, word 0 in the top bits
    typedef logic [BlockW-1:0] t_rcon [Rounds];
    localparam t_rcon RCON = '{
     {64'hb1085bda1ecadae9,64'hebcb2f81c0657c1f,64'h2f6a76432e45d016,64'h714eb88d7585c4fc,
      64'h4b7ce09192676901,64'ha2422a08a460d315,64'h05767436cc744d23,64'hdd806559f2a64507},
     {64'h6fa3b58aa99d2f1a,64'h4fe39d460f70b5d7,64'hf3feea720a232b98,64'h61d55e0f16b50131,
      64'h9ab5176b12d69958,64'h5cb561c2db0aa7ca,64'h55dda21bd7cbcd56,64'he679047021b19bb7},
     {64'hf574dcac2bce2fc7,64'h0a39fc286a3d8435,64'h06f15e5f529c1f8b,64'hf2ea7514b1297b7b,
      64'hd3e20fe490359eb1,64'hc1c93a376062db09,64'hc2b6f443867adb31,64'h991e96f50aba0ab2},
     {64'hef1fdfb3e81566d2,64'hf948e1a05d71e4dd,64'h488e857e335c3c7d,64'h9d721cad685e353f,
      64'ha9d72c82ed03d675,64'hd8b71333935203be,64'h3453eaa193e837f1,64'h220cbebc84e3d12e},
     {64'h4bea6bacad474799,64'h9a3f410c6ca92363,64'h7f151c1f1686104a,64'h359e35d7800fffbd,
      64'hbfcd1747253af5a3,64'hdfff00b723271a16,64'h7a56a27ea9ea63f5,64'h601758fd7c6cfe57},
     {64'hae4faeae1d3ad3d9,64'h6fa4c33b7a3039c0,64'h2d66c4f95142a46c,64'h187f9ab49af08ec6,
      64'hcffaa6b71c9ab7b4,64'h0af21f66c2bec6b6,64'hbf71c57236904f35,64'hfa68407a46647d6e},
     {64'hf4c70e16eeaac5ec,64'h51ac86febf240954,64'h399ec6c7e6bf87c9,64'hd3473e33197a93c9,
      64'h0992abc52d822c37,64'h06476983284a0504,64'h3517454ca23c4af3,64'h8886564d3a14d493},
     {64'h9b1f5b424d93c9a7,64'h03e7aa020c6e4141,64'h4eb7f8719c36de1e,64'h89b4443b4ddbc49a,
      64'hf4892bcb929b0690,64'h69d18d2bd1a5c42f,64'h36acc2355951a8d9,64'ha47f0dd4bf02e71e},
     {64'h378f5a541631229b,64'h944c9ad8ec165fde,64'h3a7d3a1b25894224,64'h3cd955b7e00d0984,
      64'h800a440bdbb2ceb1,64'h7b2b8a9aa6079c54,64'h0e38dc92cb1f2a60,64'h7261445183235adb},
     {64'habbedea680056f52,64'h382ae548b2e4f3f3,64'h8941e71cff8a78db,64'h1fffe18a1b336103,
      64'h9fe76702af69334b,64'h7a1e6c303b7652f4,64'h3698fad1153bb6c3,64'h74b4c7fb98459ced},
     {64'h7bcd9ed0efc889fb,64'h3002c6cd635afe94,64'hd8fa6bbbebab0761,64'h2001802114846679,
      64'h8a1d71efea48b9ca,64'hefbacd1d7d476e98,64'hdea2594ac06fd85d,64'h6bcaa4cd81f32d1b},
     {64'h378ee767f11631ba,64'hd21380b00449b17a,64'hcda43c32bcdf1d77,64'hf82012d430219f9b,
      64'h5d80ef9d1891cc86,64'he71da4aa88e12852,64'hfaf417d5d9b21b99,64'h48bc924af11bd720}
    };

    // one row of the linear map: byte-wise halving in GF(2^8)
    function automatic logic [63:0] lrow(input int unsigned k);
        logic [63:0] row;
        row = LSEED[k / 8];
        for (int r = 0; r < 8; r++) begin
            if (r < int'(k % 8))
                row = ((row >> 1) & 64'h7f7f7f7f7f7f7f7f)
                    ^ ((row & 64'h0101010101010101) * 64'h8e);
        end
        return row;
    endfunction

endpackage

// ===== hw/rtl/sbg_lps.sv =====
//------------------------------------------------------------------------------
// sbg_lps: one shared LPS transform
// Substitution, byte transpose and linear map over a 512-bit block, combinational.
//------------------------------------------------------------------------------
module sbg_lps import sbg_pkg::*; (
    input  t_block i_data,
    output t_block o_data
);

    t_block w_tp;

    // substitute and transpose: out word i, byte j = S(in word j, byte i)
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            for (int j = 0; j < 8; j++) begin
                w_tp[BlockW-1-64*i-8*j -: 8] = SBOX[i_data[BlockW-1-64*j-8*i -: 8]];
            end
        end
    end

    // linear map per word
    always_comb begin
        logic [63:0] acc;
        logic [63:0] x;
        for (int i = 0; i < 8; i++) begin
            x   = w_tp[BlockW-1-64*i -: 64];
            acc = '0;
            for (int k = 0; k < 64; k++) begin
                if (x[63-k]) acc = acc ^ lrow(k);
            end
            o_data[BlockW-1-64*i -: 64] = acc;
        end
    end

endmodule

// ===== hw/rtl/streebog512_hash.sv =====
//------------------------------------------------------------------------------
// streebog512_hash: 512-bit hash engine
// Iterative compression around one shared LPS unit.
//------------------------------------------------------------------------------
// Input channel: i_valid/o_ready carry one 64-bit message word per handshake,
// eight words per block, most significant first. The flags of the eighth word
// mark the padded final block and its unpadded bit count.
// Words 1..7 of a block are only stored. The eighth word starts a
// compression: 1 key step, 1 load, 12 rounds of 3 steps, 1 finish, during
// which o_ready is low; the LPS unit serves the key step and two steps per round.
// A final block runs three compressions, then eight digest words
// leave on o_valid/i_ready, one per accepted handshake, most significant first.
// A stalled receiver holds the current word; no input is taken until the last
// digest word is accepted, after which the state is cleared for a new message.
// Reset (i_rst_n low, synchronous) clears chain, length and checksum.
//------------------------------------------------------------------------------
module streebog512_hash import sbg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_message_word,
    input  logic        i_is_final_block,
    input  logic [8:0]  i_final_bit_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_digest_last
);

    t_state       r_state, n_state;
    t_block       r_h, n_h, r_n, n_n, r_sig, n_sig, r_m, n_m;
    t_block       r_key, n_key, r_st, n_st;
    logic [2:0]   r_pos, n_pos;
    logic [3:0]   r_rnd, n_rnd;
    logic [1:0]   r_pass, n_pass;   // 0 block, 1 length, 2 checksum
    logic         r_final, n_final;
    logic [8:0]   r_cnt, n_cnt;
    t_block       w_lps_in, w_lps_out;

    sbg_lps u_lps (.i_data(w_lps_in), .o_data(w_lps_out));

    assign o_ready        = (r_state == ST_LOAD);
    assign o_valid        = (r_state == ST_OUT);
    assign o_digest_word  = r_h[BlockW-1-64*r_pos -: 64];
    assign o_digest_index = r_pos;
    assign o_digest_last  = (r_pos == 3'd7);

    // LPS operand select
    always_comb begin
        unique case (r_state)
            ST_KEY0:   w_lps_in = (r_pass == 2'd0) ? (r_h ^ r_n) : r_h;
            ST_RSTATE: w_lps_in = r_st;
            ST_RKEY:   w_lps_in = r_key ^ RCON[r_rnd];
            default:   w_lps_in = '0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_h = r_h; n_n = r_n; n_sig = r_sig; n_m = r_m;
        n_key = r_key; n_st = r_st; n_pos = r_pos; n_rnd = r_rnd;
        n_pass = r_pass; n_final = r_final; n_cnt = r_cnt;
        unique case (r_state)
            ST_LOAD: begin
                if (i_valid) begin
                    n_m[BlockW-1-64*r_pos -: 64] = i_message_word;
                    n_pos = r_pos + 3'd1;
                    if (r_pos == 3'd7) begin
                        n_final = i_is_final_block;
                        n_cnt   = i_final_bit_count;
                        n_pass  = 2'd0;
                        n_state = ST_KEY0;
                    end
                end
            end
            ST_KEY0: begin
                n_key = w_lps_out;
                n_state = ST_INIT;
            end
            ST_INIT: begin
                n_st = r_key ^ r_m;
                n_rnd = '0;
                n_state = ST_RSTATE;
            end
            ST_RSTATE: begin
                n_st = w_lps_out;
                n_state = ST_RKEY;
            end
            ST_RKEY: begin
                n_key = w_lps_out;
                n_state = ST_RMIX;
            end
            ST_RMIX: begin
                n_st = r_st ^ r_key;
                if (r_rnd == 4'(Rounds - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_rnd = r_rnd + 4'd1;
                    n_state = ST_RSTATE;
                end
            end
            ST_FIN: begin
                n_h = r_h ^ r_st ^ r_m;
                priority case (r_pass)
                    2'd0: begin
                        n_sig = r_sig + r_m;
                        if (r_final) begin
                            n_n = r_n + BlockW'(r_cnt);
                            n_m = n_n;
                            n_pass = 2'd1;
                            n_state = ST_KEY0;
                        end else begin
                            n_n = r_n + BlockW'(BlockW);
                            n_state = ST_LOAD;
                        end
                    end
                    2'd1: begin
                        n_m = r_sig;
                        n_pass = 2'd2;
                        n_state = ST_KEY0;
                    end
                    default: begin
                        n_pos = '0;
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_pos = r_pos + 3'd1;
                    if (r_pos == 3'd7) begin
                        n_h = '0; n_n = '0; n_sig = '0;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_pos   <= '0;
            r_h     <= '0;
            r_n     <= '0;
            r_sig   <= '0;
            r_pass  <= '0;
            r_rnd   <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_h     <= n_h;
            r_n     <= n_n;
            r_sig   <= n_sig;
            r_pass  <= n_pass;
            r_rnd   <= n_rnd;
            r_final <= n_final;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_key <= n_key;
        r_st  <= n_st;
        r_cnt <= n_cnt;
    end

    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_pos_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_digest_index == 3'd0) else $error("digest not at word 0");
    a_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd < 4'(Rounds)) else $error("round overrun");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_digest_last |=> r_h == '0 && r_n == '0)
        else $error("state not cleared");

endmodule
